// ----- hw/rtl/lcs_pkg.sv -----
package lcs_pkg;

	// Field and register widths.
	localparam int MOD_MAX = 64;
	localparam int MOD_W   = 7;
	localparam int RES_W   = 6;
	localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(16);
	localparam logic [MOD_W-1:0] MOD_MIN   = MOD_W'(2);
	localparam logic [MOD_W-1:0] MOD_TOP   = MOD_W'(MOD_MAX);

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // capture a new item and clear the scan
		logic reduce;  // subtract the modulus from operands not yet below it
		logic step;    // advance the candidate and the running product
		logic take;    // current candidate solves; queue it, emit the older one
		logic final_;  // emit the closing result of the item
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic reduced;   // both operands are below the modulus
		logic match;     // a*x mod m equals b for the current candidate
		logic at_end;    // current candidate is m-1
		logic pend_vld;  // a solution is waiting to be emitted
		logic out_free;  // output register can take an item this cycle
	} sts_t;

endpackage

// ----- hw/rtl/lcs_ctrl.sv -----
module lcs_ctrl
	import lcs_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  sts_t   sts,
	output cmd_t   cmd
);

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				if (sts.reduced) begin
					state_d = ST_SCAN;
				end else begin
					cmd.reduce = 1'b1;
				end
			end
			ST_SCAN: begin
				// A hit with a queued solution needs room in the output register.
				if (!(sts.match && sts.pend_vld && !sts.out_free)) begin
					cmd.step = 1'b1;
					cmd.take = sts.match;
					if (sts.at_end) begin
						state_d = ST_FLUSH;
					end
				end
			end
			ST_FLUSH: begin
				if (sts.out_free) begin
					cmd.final_ = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- hw/rtl/lcs_dp.sv -----
module lcs_dp
	import lcs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [MOD_W-1:0] cfg_data,
	input  logic             cfg_we,
	input  logic [RES_W-1:0] coef_a,
	input  logic [RES_W-1:0] rhs_b,
	input  cmd_t             cmd,
	output sts_t             sts,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [RES_W-1:0] out_solution,
	output logic             out_has_solution,
	output logic             out_last
);

	logic [MOD_W-1:0] mod_q;
	logic [MOD_W-1:0] m_eff;
	logic [RES_W-1:0] a_q, b_q, acc_q, x_q, pend_q;
	logic             pend_vld_q;
	logic [RES_W-1:0] out_sol_q;
	logic             out_ok_q, out_last_q, out_vld_q;
	logic [MOD_W-1:0] sum;
	logic [RES_W-1:0] acc_next;
	logic             a_big, b_big;
	logic             push;

	// Modulus register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= MOD_RESET;
		end else if (cfg_we) begin
			mod_q <= cfg_data;
		end
	end

	// Clamp the modulus into its meaningful range.
	always_comb begin
		m_eff = mod_q;
		if (mod_q < MOD_MIN) begin
			m_eff = MOD_MIN;
		end else if (mod_q > MOD_TOP) begin
			m_eff = MOD_TOP;
		end
	end

	// Operand reduction compares and running product a*x mod m.
	assign a_big    = {1'b0, a_q} >= m_eff;
	assign b_big    = {1'b0, b_q} >= m_eff;
	assign sum      = {1'b0, acc_q} + {1'b0, a_q};
	assign acc_next = (sum >= m_eff) ? RES_W'(sum - m_eff) : sum[RES_W-1:0];

	// Status toward the controller.
	assign push         = (cmd.take && pend_vld_q) || cmd.final_;
	assign sts.reduced  = !a_big && !b_big;
	assign sts.match    = acc_q == b_q;
	assign sts.at_end   = {1'b0, x_q} == (m_eff - MOD_W'(1));
	assign sts.pend_vld = pend_vld_q;
	assign sts.out_free = !out_vld_q || out_ready;

	// Operands, candidate and running product.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q   <= coef_a;
			b_q   <= rhs_b;
			acc_q <= '0;
			x_q   <= '0;
		end else begin
			if (cmd.reduce) begin
				if (a_big) a_q <= RES_W'({1'b0, a_q} - m_eff);
				if (b_big) b_q <= RES_W'({1'b0, b_q} - m_eff);
			end
			if (cmd.step) begin
				acc_q <= acc_next;
				x_q   <= x_q + RES_W'(1);
			end
		end
	end

	// Queued solution, held back until it is known whether it is the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
		end else if (cmd.load || cmd.final_) begin
			pend_vld_q <= 1'b0;
		end else if (cmd.take) begin
			pend_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			pend_q <= x_q;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (push) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_sol_q  <= pend_vld_q ? pend_q : '0;
			out_ok_q   <= pend_vld_q;
			out_last_q <= cmd.final_;
		end
	end

	assign out_valid        = out_vld_q;
	assign out_solution     = out_sol_q;
	assign out_has_solution = out_ok_q;
	assign out_last         = out_last_q;

	// An item is never written over one that has not been taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && out_vld_q) |-> out_ready)
		else $error("output register overwritten");

	// The scan only runs on a reduced coefficient with the product below the modulus.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (!a_big && ({1'b0, acc_q} < m_eff)))
		else $error("scan on unreduced values");

	// Closing without a queued solution reports no solution.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.final_ && !pend_vld_q) |=> (!out_ok_q && out_last_q && out_sol_q == '0))
		else $error("bad no-solution result");

	// Only one of load, reduce, scan step and close is issued in a cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.step, cmd.final_, cmd.reduce}))
		else $error("conflicting commands");

endmodule

// ----- hw/rtl/linear_congruence_solver_core.sv -----
// Steps: load the item, reduce both operands below the modulus m, scan the
// candidates 0..m-1 with one adder and compare per cycle, then close.
// One item at a time; the scan stalls on a hit while a queued solution waits
// for room in the output register, and the close waits for that room too.
// Reset (arst_n low, asynchronous) sets the modulus to 16 and empties the block.
module linear_congruence_solver_core
	import lcs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [MOD_W-1:0] cfg_data,   // modulus
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [15:0]      s_tdata,    // [5:0] coef_a, [11:6] rhs_b, [15:12] zero
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,    // [5:0] solution, [7:6] zero
	output logic             m_tuser,    // has_solution
	output logic             m_tlast
);

	cmd_t             cmd;
	sts_t             sts;
	logic [RES_W-1:0] solution;

	// The modulus register takes a write in any cycle.
	assign cfg_ready = 1'b1;

	lcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lcs_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_data         (cfg_data),
		.cfg_we           (cfg_valid),
		.coef_a           (s_tdata[5:0]),
		.rhs_b            (s_tdata[11:6]),
		.cmd              (cmd),
		.sts              (sts),
		.out_valid        (m_tvalid),
		.out_ready        (m_tready),
		.out_solution     (solution),
		.out_has_solution (m_tuser),
		.out_last         (m_tlast)
	);

	assign m_tdata = {2'b00, solution};

endmodule
